// ===== src/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table lookup
// Field widths, request kinds, table entry layout, compare result and
// sequencer state codes.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int KEY_W    = 64;
   localparam int SLOT_W   = 12;
   localparam int MOVE_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 13;

   // Request kinds carried on req_tuser
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [MOVE_W-1:0]   move;
      logic [KEY_W-1:0]    key;
   } entry_type;

   // Result of the shared key compare unit
   typedef struct packed {
      logic lt;   // stored key below search key
      logic eq;   // stored key equals search key
   } cmp_res_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_BSTEP = 7'b0000010,
      ST_BREAD = 7'b0000100,
      ST_BCMP = 7'b0001000,
      ST_SSTEP = 7'b0010000,
      ST_SCMP = 7'b0100000,
      ST_RESP = 7'b1000000
   } state_type;

endpackage

// ===== src/skt_key_cmp.sv =====
// ----------------------------------------------------------------------------
// skt_key_cmp: shared 64-bit key compare unit
// Gives less-than and equal for a stored key against the search key; used
// by both the binary search and the forward scan.
// ----------------------------------------------------------------------------
module skt_key_cmp (
   input  logic [skt_pkg::KEY_W-1:0] stored_key,
   input  logic [skt_pkg::KEY_W-1:0] search_key,
   output skt_pkg::cmp_res_type      res
);
   import skt_pkg::*;

   always_comb begin
      res.lt = stored_key < search_key;
      res.eq = stored_key == search_key;
   end

endmodule

// ===== src/sorted_key_table_best_weight_lookup.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_best_weight_lookup: sorted key table with best-weight query
// Load requests write one entry; query requests binary-search for the first
// entry with the key and scan the run of equal keys for the heaviest move.
// ----------------------------------------------------------------------------
// Sequencing: a load is written at acceptance and leaves req_tready high. A query
//   runs a binary search of at most ceil(log2(n+1)) probes, then scans the run
//   of matching entries, and then raises rsp_tvalid.
// Throughput: one request at a time; req_tready is low from a query's
//   acceptance until its response is taken. Every probe goes through the
//   single table read port (registered read data) and one key comparator.
// Reset: clears the sequencer, the response valid and entry_count; the
//   table contents are not cleared.
module sorted_key_table_best_weight_lookup #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: key[63:0], slot[75:64], entry_move[91:76],
   //            entry_weight[107:92], zero[111:108]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic [0:0]   req_tuser,   // func[0]
   // rsp_tdata: chosen move[15:0], chosen weight[31:16]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   output logic [0:0]   rsp_tuser,   // found[0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [skt_pkg::COUNT_W-1:0] csr_data
);
   import skt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [KEY_W-1:0]    req_key;
   logic [SLOT_W-1:0]   req_slot;
   logic [MOVE_W-1:0]   req_move;
   logic [WEIGHT_W-1:0] req_weight;
   logic                req_fire;
   logic [31:0]         slot_wide;
   logic [31:0]         count_wide;
   logic [CW-1:0]       valid_n;

   entry_type           table_mem [TABLE_DEPTH];
   entry_type           rd_data_ff;
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  entry_count_ff;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [MOVE_W-1:0]   sel_move_ff, sel_move_in;
   logic [WEIGHT_W-1:0] sel_weight_ff, sel_weight_in;
   cmp_res_type         cmp;

   assign req_key    = req_tdata[63:0];
   assign req_slot   = req_tdata[75:64];
   assign req_move   = req_tdata[91:76];
   assign req_weight = req_tdata[107:92];

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign slot_wide  = 32'(req_slot);
   assign count_wide = 32'(entry_count_ff);
   // Clamp the count to the table size
   assign valid_n = (count_wide > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count_ff);

   // Drop loads whose slot is past the end of the table
   assign mem_we = req_fire && (req_tuser[0] == FUNC_LOAD) && (slot_wide < 32'(TABLE_DEPTH));
   assign mem_re = (state_ff == ST_BREAD) || ((state_ff == ST_SSTEP) && (idx_ff < n_ff));
   assign mem_raddr = (state_ff == ST_BREAD) ? mid_ff[AW-1:0] : idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[slot_wide[AW-1:0]] <= '{weight: req_weight, move: req_move, key: req_key};
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_raddr];
      end
   end

   skt_key_cmp u_cmp (
      .stored_key (rd_data_ff.key),
      .search_key (key_ff),
      .res        (cmp)
   );

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      n_in          = n_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      sel_move_in   = sel_move_ff;
      sel_weight_in = sel_weight_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser[0] == FUNC_QUERY)) begin
               key_in        = req_key;
               n_in          = valid_n;
               lo_in         = '0;
               hi_in         = valid_n;
               found_in      = 1'b0;
               sel_move_in   = '0;
               sel_weight_in = '0;
               state_in      = ST_BSTEP;
            end
         end
         ST_BSTEP: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               state_in = ST_BREAD;
            end else begin
               idx_in   = lo_ff;
               state_in = ST_SSTEP;
            end
         end
         ST_BREAD: begin
            state_in = ST_BCMP;
         end
         ST_BCMP: begin
            if (cmp.lt) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_BSTEP;
         end
         ST_SSTEP: begin
            state_in = (idx_ff < n_ff) ? ST_SCMP : ST_RESP;
         end
         ST_SCMP: begin
            if (!cmp.eq) begin
               state_in = ST_RESP;
            end else begin
               // Keep the earliest entry on equal weight
               if (!found_ff || (rd_data_ff.weight > sel_weight_ff)) begin
                  found_in      = 1'b1;
                  sel_move_in   = rd_data_ff.move;
                  sel_weight_in = rd_data_ff.weight;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SSTEP;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            entry_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      sel_move_ff   <= sel_move_in;
      sel_weight_ff <= sel_weight_in;
   end

   assign rsp_tvalid   = state_ff == ST_RESP;
   assign rsp_tdata    = {sel_weight_ff, sel_move_ff};
   assign rsp_tuser[0] = found_ff;

endmodule

// ===== src/skt_checker.sv =====
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table lookup
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
module skt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);
   import skt_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == FUNC_QUERY) |=> !req_tready)
      else $error("ready right after a query request");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == FUNC_LOAD) |=> req_tready && !rsp_tvalid)
      else $error("load request did not finish in one cycle");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss response carries nonzero data");

endmodule

bind sorted_key_table_best_weight_lookup skt_checker u_skt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
